// ----- hw/rtl/pq_pkg.sv -----
package pq_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OCC_W   = 5;

   // operation codes on the kind field
   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_EXTRACT = 2'd1;
   localparam logic [1:0] KIND_CHANGE  = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        payload;
      logic signed [KEY_W-1:0]   new_key;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [VALUE_W-1:0]  value_out;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // one stored queue entry
   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic [VALUE_W-1:0]       value;
   } entry_type;

endpackage

// ----- hw/rtl/sorted_min_priority_queue.sv -----
// Steps: insert walks from the back, moving each entry with a key >= the new key back one
//   slot; extract returns the front value and pulls later entries forward; change searches
//   from the front, removes the match and inserts it with new_key; rejects and no-ops go to done.
// Throughput: one operation at a time, the next beat taken in the cycle after the result loads;
//   the walk through the entry memory with one read port and the shared compare unit sets it.
// Reset: synchronous, active high; clears the count and control state, not the entry storage.
module sorted_min_priority_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pq_pkg::req_type   req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pq_pkg::rsp_type   rsp_data
);
   import pq_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic        seq_idle;
   logic        done_valid;
   logic        done_ready;
   rsp_type     result;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   entry_type   wr_data;
   entry_type   rd_data;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   pq_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pq_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid & seq_idle),
      .cmd        (req_data),
      .idle       (seq_idle),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .result     (result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   assign req_ready  = seq_idle;
   assign done_ready = !rsp_valid_ff || rsp_ready;

   // output register: load a finished result, drop the beat once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/pq_mem.sv -----
module pq_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  pq_pkg::entry_type    wr_data,
   input  logic [AW-1:0]        rd_addr,
   output pq_pkg::entry_type    rd_data
);
   import pq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pq_seq.sv -----
module pq_seq #(
   parameter int unsigned CAPACITY = 16,
   parameter int unsigned AW       = 4,
   parameter int unsigned CW       = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pq_pkg::req_type     cmd,
   output logic                idle,
   output logic                done_valid,
   input  logic                done_ready,
   output pq_pkg::rsp_type     result,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output pq_pkg::entry_type   wr_data,
   output logic [AW-1:0]       rd_addr,
   input  pq_pkg::entry_type   rd_data
);
   import pq_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_EXT_RD = 8'b0000_0010,
      S_FIND   = 8'b0000_0100,
      S_DN_CHK = 8'b0000_1000,
      S_DN_MOV = 8'b0001_0000,
      S_UP_CHK = 8'b0010_0000,
      S_UP_CMP = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE       = CW'(1);

   state_type            state_ff, state_in;
   req_type              cmd_ff, cmd_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   entry_type            ins_ff, ins_in;
   status_type           status_ff, status_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [CW-1:0]        idx_next;
   logic                 key_ge;
   logic                 key_eq;

   // shared compare unit: stored key against the key in flight
   assign key_ge   = $signed(rd_data.key) >= $signed(ins_ff.key);
   assign key_eq   = rd_data.key == cmd_ff.key;
   assign idx_next = idx_ff + ONE;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      ins_in    = ins_ff;
      status_in = status_ff;
      value_in  = value_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = ins_ff;
      rd_addr   = idx_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = '0;
            if (start) begin
               cmd_in    = cmd;
               status_in = ST_OK;
               value_in  = '0;
               idx_in    = '0;
               unique case (cmd.kind)
                  KIND_INSERT: begin
                     ins_in.key   = cmd.key;
                     ins_in.value = cmd.payload;
                     idx_in       = count_ff;
                     if (count_ff >= CAP_COUNT) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in  = S_UP_CHK;
                     end
                  end
                  KIND_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in  = S_EXT_RD;
                     end
                  end
                  KIND_CHANGE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                        state_in  = S_DONE;
                     end else begin
                        state_in  = S_FIND;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // front entry has arrived: return its value, then close the gap
         S_EXT_RD: begin
            value_in = rd_data.value;
            state_in = S_DN_CHK;
         end
         // walk from the front for the first matching key
         S_FIND: begin
            rd_addr = idx_next[AW-1:0];
            if (key_eq) begin
               ins_in.value = rd_data.value;
               state_in     = S_DN_CHK;
            end else if (idx_next >= count_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in = idx_next;
            end
         end
         // close the gap at idx: pull the next entry down or finish
         S_DN_CHK: begin
            rd_addr = idx_next[AW-1:0];
            if (idx_next >= count_ff) begin
               count_in = count_ff - ONE;
               if (cmd_ff.kind == KIND_CHANGE) begin
                  ins_in.key = cmd_ff.new_key;
                  idx_in     = count_ff - ONE;
                  state_in   = S_UP_CHK;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DN_MOV;
            end
         end
         S_DN_MOV: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_next;
            state_in = S_DN_CHK;
         end
         // open a hole at idx, walking from the back
         S_UP_CHK: begin
            rd_addr = AW'(idx_ff - ONE);
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + ONE;
               state_in = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (key_ge) begin
               wr_data  = rd_data;
               idx_in   = idx_ff - ONE;
               state_in = S_UP_CHK;
            end else begin
               count_in = count_ff + ONE;
               state_in = S_DONE;
            end
         end
         // hold the result until the output register takes it
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      ins_ff    <= ins_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign idle             = state_ff == S_IDLE;
   assign done_valid       = state_ff == S_DONE;
   assign result.status    = status_ff;
   assign result.value_out = value_ff;
   assign result.occupancy = OCC_W'(count_ff);

endmodule

// ----- test/sorted_min_priority_queue_tb.sv -----
`timescale 1ns / 100ps

module sorted_min_priority_queue_tb;
   import pq_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam logic [1:0] KIND_IDLE = 2'd3;
   localparam logic signed [KEY_W-1:0] MIN_KEY = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] MAX_KEY = {1'b0, {(KEY_W-1){1'b1}}};

   // shadow copy of the sorted entry list and the replies it predicts
   class min_queue_model;
      logic signed [KEY_W-1:0] keys [DEPTH];
      logic [VALUE_W-1:0]      vals [DEPTH];
      int unsigned             held = 0;
      rsp_type                 replies_due [$];
      int unsigned             mismatches = 0;

      // first slot whose key is greater than or equal to k
      function int unsigned slot_for(input logic signed [KEY_W-1:0] k);
         int unsigned i;
         i = 0;
         while (i < held && keys[i] < k) i++;
         return i;
      endfunction

      function void insert_at(input int unsigned pos, input logic signed [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v);
         for (int unsigned j = held; j > pos; j--) begin
            keys[j] = keys[j-1];
            vals[j] = vals[j-1];
         end
         keys[pos] = k;
         vals[pos] = v;
         held++;
      endfunction

      function void remove_at(input int unsigned pos);
         for (int unsigned j = pos; j + 1 < held; j++) begin
            keys[j] = keys[j+1];
            vals[j] = vals[j+1];
         end
         held--;
      endfunction

      // apply one accepted request beat and queue the reply it must produce
      function void apply_op(input req_type r);
         rsp_type                due;
         int unsigned            i;
         logic [VALUE_W-1:0]     v;
         due.status    = ST_OK;
         due.value_out = '0;
         case (r.kind)
            KIND_INSERT: begin
               if (held >= DEPTH) due.status = ST_FULL;
               else insert_at(slot_for(r.key), r.key, r.payload);
            end
            KIND_EXTRACT: begin
               if (held == 0) begin
                  due.status = ST_EMPTY;
               end else begin
                  due.value_out = vals[0];
                  remove_at(0);
               end
            end
            KIND_CHANGE: begin
               i = 0;
               while (i < held && keys[i] != r.key) i++;
               if (i >= held) begin
                  due.status = ST_NOT_FOUND;
               end else begin
                  v = vals[i];
                  remove_at(i);
                  insert_at(slot_for(r.new_key), r.new_key, v);
               end
            end
            default: ;
         endcase
         due.occupancy = held[OCC_W-1:0];
         replies_due.push_back(due);
      endfunction

      // compare one reply beat against the oldest prediction
      function void check_reply(input rsp_type got);
         rsp_type due;
         if (replies_due.size() == 0) begin
            $display("%0t: reply beat with none due: status %0d value %h occupancy %0d",
                     $time, got.status, got.value_out, got.occupancy);
            mismatches++;
            return;
         end
         due = replies_due[0];
         replies_due.delete(0);
         if (got.status !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, got.status);
            mismatches++;
         end
         if (got.value_out !== due.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time, due.value_out,
                     got.value_out);
            mismatches++;
         end
         if (got.occupancy !== due.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, due.occupancy,
                     got.occupancy);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    rsp_ready = 1'b0;
   wire     req_ready;
   wire     rsp_valid;
   rsp_type rsp_data;

   min_queue_model board;
   bit             calm = 1'b0;

   sorted_min_priority_queue #(.CAPACITY(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // idle length: mostly none or short, a few long; none at all in calm stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // keys cluster near zero so that ties and change hits are common
   function automatic logic signed [KEY_W-1:0] random_key();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return int'($urandom_range(0, 8)) - 4;
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0: return MIN_KEY;
            1: return MAX_KEY;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic req_type make_req(input logic [1:0] kind,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [VALUE_W-1:0] payload,
                                        input logic signed [KEY_W-1:0] new_key);
      req_type r;
      r.kind    = kind;
      r.key     = key;
      r.payload = payload;
      r.new_key = new_key;
      return r;
   endfunction

   // present one request beat after an optional gap; return at the next falling edge
   task automatic send_item(input req_type r, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.apply_op(r);
      @(negedge clock);
   endtask

   // hold the sender until every predicted reply has arrived
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      while (board.replies_due.size() != 0) @(negedge clock);
   endtask

   // reply side: stall at random, check every accepted beat
   initial begin
      int unsigned stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_reply(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_type                 r;
      int unsigned             sent, phase_len, mode, roll, ins_pct, ext_pct;
      logic signed [KEY_W-1:0] k;
      board = new;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue: extract, change and the unused kind
      send_item(make_req(KIND_EXTRACT, 0, 0, 0), 0);
      send_item(make_req(KIND_CHANGE, 0, 0, 1), 0);
      send_item(make_req(KIND_IDLE, MIN_KEY, '1, MAX_KEY), 0);
      // extreme keys and a tie, the later equal key goes in front
      send_item(make_req(KIND_INSERT, MIN_KEY, '0, 0), 0);
      send_item(make_req(KIND_INSERT, MAX_KEY, '1, 0), 0);
      send_item(make_req(KIND_INSERT, 0, 32'h1111_0000, 0), 0);
      send_item(make_req(KIND_INSERT, 0, 32'h2222_0000, 0), 0);
      // move a tied key onto another tie, then miss a key
      send_item(make_req(KIND_CHANGE, 0, 0, MAX_KEY), 0);
      send_item(make_req(KIND_CHANGE, 5, 0, MIN_KEY), 0);
      send_item(make_req(KIND_IDLE, 0, 32'hDEAD_BEEF, 0), 0);
      send_item(make_req(KIND_EXTRACT, 0, 0, 0), 0);
      send_item(make_req(KIND_INSERT, -1, 32'h5555_AAAA, 0), 0);
      // fill to capacity, overflow once, change while full
      for (int i = 0; i < 12; i++)
         send_item(make_req(KIND_INSERT, (i % 2) ? -i : i * 1000, $urandom, 0), 0);
      send_item(make_req(KIND_INSERT, 7, 32'hFFFF_0000, 0), 0);
      send_item(make_req(KIND_CHANGE, -1, 0, MIN_KEY), 0);
      wait_for_replies();

      // random phases biased toward filling, draining or neither
      sent = 0;
      while (sent < 1800) begin
         phase_len = $urandom_range(30, 90);
         mode      = $urandom_range(0, 2);
         calm      = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) wait_for_replies();
         ins_pct = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
         ext_pct = (mode == 0) ? 15 : (mode == 1) ? 55 : 30;
         repeat (phase_len) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
               r = make_req(KIND_INSERT, random_key(), $urandom, $urandom);
            end else if (roll < ins_pct + ext_pct) begin
               r = make_req(KIND_EXTRACT, $urandom, $urandom, $urandom);
            end else if (roll < 97) begin
               // search mostly for a key that is held
               if (board.held > 0 && $urandom_range(0, 3) != 0)
                  k = board.keys[$urandom_range(0, board.held - 1)];
               else
                  k = random_key();
               r = make_req(KIND_CHANGE, k, $urandom, random_key());
            end else begin
               r = make_req(KIND_IDLE, $urandom, $urandom, $urandom);
            end
            send_item(r, pick_gap());
            sent++;
         end
      end

      // drain and let any stray beat show up
      wait_for_replies();
      repeat (200) @(negedge clock);
      if (board.mismatches == 0 && board.replies_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
